// File: rtl/ale_pkg.sv
`timescale 1ns / 1ps

package ale_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int WORD_WIDTH_DEF = 32;

  // fixed field widths of the request and result beats
  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 7;
  localparam int LEN_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND  = 3'd0,
    F_INSERT  = 3'd1,
    F_DELETE  = 3'd2,
    F_READ    = 3'd3,
    F_FIND    = 3'd4,
    F_REVERSE = 3'd5
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // datapath micro-operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_INS_START,
    OP_INS_MOVE,
    OP_INS_PLACE,
    OP_DEL_START,
    OP_DEL_MOVE,
    OP_READ,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_REV_START,
    OP_REV_WA,
    OP_REV_WB
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
    status_t status;
    logic    take_read;
    logic    take_index;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  full;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  del_shift;
    logic  cnt_zero;
    logic  cnt_gt1;
    logic  ins_more;
    logic  del_more;
    logic  scan_match;
    logic  scan_more;
    logic  rev_more;
  } dp_flags_t;

endpackage

// File: rtl/ale_datapath.sv
`timescale 1ns / 1ps

module ale_datapath #(
  parameter int DEPTH      = ale_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = ale_pkg::WORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ale_pkg::FUNC_W-1:0]        func,
  input  logic [ale_pkg::POS_W-1:0]         position,
  input  logic signed [ale_pkg::VAL_W-1:0]  item_value,
  input  ale_pkg::dp_cmd_t                  cmd,
  output ale_pkg::dp_flags_t                flags,
  output logic                              done,
  output logic [ale_pkg::ST_W-1:0]          status,
  output logic signed [ale_pkg::VAL_W-1:0]  read_value,
  output logic [ale_pkg::IDX_W-1:0]         found_index,
  output logic [ale_pkg::LEN_W-1:0]         list_length
);
  import ale_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_a;
  logic [WORD_WIDTH-1:0] rdata_b;

  func_t                 func_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] val_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         ptr;
  logic [CW-1:0]         ptr_next;
  logic [CW-1:0]         ptr_b;
  logic [CW-1:0]         ptr_b_next;

  logic                  we;
  logic                  re_a;
  logic                  re_b;
  logic [CW-1:0]         waddr;
  logic [CW-1:0]         addr_a;
  logic [CW-1:0]         addr_b;
  logic [WORD_WIDTH-1:0] wdata;

  logic [CW-1:0]         pos_c;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         ptr_x;
  logic [XW-1:0]         ptr_b_x;

  assign pos_c   = CW'(pos_q);
  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count);
  assign ptr_x   = XW'(ptr);
  assign ptr_b_x = XW'(ptr_b);

  assign count_next = count + CW'(cmd.cnt_inc) - CW'(cmd.cnt_dec);

  always_comb begin
    flags.func       = func_q;
    flags.full       = cnt_x >= XW'(DEPTH);
    flags.pos_gt_cnt = pos_x > cnt_x;
    flags.pos_ge_cnt = pos_x >= cnt_x;
    flags.del_shift  = (pos_x + XW'(1)) < cnt_x;
    flags.cnt_zero   = count == '0;
    flags.cnt_gt1    = cnt_x > XW'(1);
    flags.ins_more   = ptr_x > (pos_x + XW'(1));
    flags.del_more   = (ptr_x + XW'(2)) < cnt_x;
    flags.scan_match = rdata_a == val_q;
    flags.scan_more  = (ptr_x + XW'(1)) < cnt_x;
    flags.rev_more   = (ptr_x + XW'(2)) < ptr_b_x;
  end

  always_comb begin
    we         = 1'b0;
    re_a       = 1'b0;
    re_b       = 1'b0;
    waddr      = count;
    wdata      = val_q;
    addr_a     = '0;
    addr_b     = '0;
    ptr_next   = ptr;
    ptr_b_next = ptr_b;
    case (cmd.op)
      OP_APPEND: begin
        we = 1'b1;
      end
      // shift up walks from the tail towards the insert position
      OP_INS_START: begin
        re_a     = 1'b1;
        addr_a   = count - CW'(1);
        ptr_next = count;
      end
      OP_INS_MOVE: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata_a;
        re_a     = 1'b1;
        addr_a   = ptr - CW'(2);
        ptr_next = ptr - CW'(1);
      end
      OP_INS_PLACE: begin
        we    = 1'b1;
        waddr = pos_c;
      end
      OP_DEL_START: begin
        re_a     = 1'b1;
        addr_a   = pos_c + CW'(1);
        ptr_next = pos_c;
      end
      OP_DEL_MOVE: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata_a;
        re_a     = 1'b1;
        addr_a   = ptr + CW'(2);
        ptr_next = ptr + CW'(1);
      end
      OP_READ: begin
        re_a   = 1'b1;
        addr_a = pos_c;
      end
      OP_SCAN_START: begin
        re_a     = 1'b1;
        ptr_next = '0;
      end
      OP_SCAN_NEXT: begin
        re_a     = 1'b1;
        addr_a   = ptr + CW'(1);
        ptr_next = ptr + CW'(1);
      end
      OP_REV_START: begin
        re_a       = 1'b1;
        re_b       = 1'b1;
        addr_b     = count - CW'(1);
        ptr_next   = '0;
        ptr_b_next = count - CW'(1);
      end
      OP_REV_WA: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = rdata_b;
      end
      // second half of the swap, and fetch of the next pair
      OP_REV_WB: begin
        we         = 1'b1;
        waddr      = ptr_b;
        wdata      = rdata_a;
        re_a       = 1'b1;
        re_b       = 1'b1;
        addr_a     = ptr + CW'(1);
        addr_b     = ptr_b - CW'(1);
        ptr_next   = ptr + CW'(1);
        ptr_b_next = ptr_b - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[addr_a[IW-1:0]];
    end
    if (re_b) begin
      rdata_b <= mem[addr_b[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    ptr_b <= ptr_b_next;
    if (cmd.op == OP_LOAD) begin
      func_q <= func_t'(func);
      pos_q  <= position;
      val_q  <= WORD_WIDTH'($unsigned(item_value));
    end
    if (cmd.finish) begin
      status      <= cmd.status;
      read_value  <= cmd.take_read ? VAL_W'(rdata_a) : '0;
      found_index <= cmd.take_index ? IDX_W'(ptr) : '0;
      list_length <= LEN_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= XW'(DEPTH))
    else $error("entry count above depth");

  a_no_grow_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !flags.full)
    else $error("entry count raised on a full list");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

// File: rtl/ale_ctrl.sv
`timescale 1ns / 1ps

module ale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ale_pkg::dp_flags_t flags,
  output logic               busy,
  output ale_pkg::dp_cmd_t   cmd
);
  import ale_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DECODE     = 9'b000000010,
    S_SHIFT_UP   = 9'b000000100,
    S_PLACE      = 9'b000001000,
    S_SHIFT_DOWN = 9'b000010000,
    S_READ_WAIT  = 9'b000100000,
    S_SCAN       = 9'b001000000,
    S_REV_A      = 9'b010000000,
    S_REV_B      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.status = ST_DONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        cmd.finish = 1'b1;
        case (flags.func)
          F_APPEND: begin
            if (flags.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.op      = OP_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end
          // position test before the full test
          F_INSERT: begin
            if (flags.pos_gt_cnt) begin
              cmd.status = ST_BADPOS;
            end else if (flags.full) begin
              cmd.status = ST_FULL;
            end else if (flags.pos_ge_cnt) begin
              cmd.op      = OP_INS_PLACE;
              cmd.cnt_inc = 1'b1;
            end else begin
              cmd.op     = OP_INS_START;
              cmd.finish = 1'b0;
              state_next = S_SHIFT_UP;
            end
          end
          F_DELETE: begin
            if (flags.pos_ge_cnt) begin
              cmd.status = ST_BADPOS;
            end else if (flags.del_shift) begin
              cmd.op     = OP_DEL_START;
              cmd.finish = 1'b0;
              state_next = S_SHIFT_DOWN;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          F_READ: begin
            if (flags.pos_ge_cnt) begin
              cmd.status = ST_BADPOS;
            end else begin
              cmd.op     = OP_READ;
              cmd.finish = 1'b0;
              state_next = S_READ_WAIT;
            end
          end
          F_FIND: begin
            if (flags.cnt_zero) begin
              cmd.status = ST_NOTFOUND;
            end else begin
              cmd.op     = OP_SCAN_START;
              cmd.finish = 1'b0;
              state_next = S_SCAN;
            end
          end
          F_REVERSE: begin
            if (flags.cnt_gt1) begin
              cmd.op     = OP_REV_START;
              cmd.finish = 1'b0;
              state_next = S_REV_A;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.op = OP_INS_MOVE;
        if (!flags.ins_more) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.op      = OP_INS_PLACE;
        cmd.cnt_inc = 1'b1;
        cmd.finish  = 1'b1;
        state_next  = S_IDLE;
      end
      S_SHIFT_DOWN: begin
        cmd.op = OP_DEL_MOVE;
        if (!flags.del_more) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_READ_WAIT: begin
        cmd.take_read = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        if (flags.scan_match) begin
          cmd.take_index = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = S_IDLE;
        end else if (flags.scan_more) begin
          cmd.op = OP_SCAN_NEXT;
        end else begin
          cmd.status = ST_NOTFOUND;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REV_A: begin
        cmd.op     = OP_REV_WA;
        state_next = S_REV_B;
      end
      S_REV_B: begin
        cmd.op = OP_REV_WB;
        if (flags.rev_more) begin
          state_next = S_REV_A;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_DECODE)
    else $error("accepted beat not decoded");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("controller busy after finishing");

  a_swap_pairs: assert property (@(posedge clk) disable iff (rst)
    state == S_REV_A |=> state == S_REV_B)
    else $error("swap left half done");

endmodule

// File: rtl/array_list_engine.sv
// Ordered list of up to DEPTH words with six operations: append, insert,
// delete, read, find and reverse. A request beat is taken when start is high
// and busy is low; its single result shows on the result ports for exactly
// one cycle with done high and cannot be held off. The list sits in a memory
// with one write port and two registered read ports, so every shift, scan or
// swap moves at most one word per cycle. Append, bad positions and a full
// list finish in the decode state; read waits for the registered read
// port; insert below the count shifts words up from the tail to the
// position, then places the item; delete of any but the last word shifts
// the words above it down; find scans up from index 0; reverse swaps pairs
// from both ends. busy falls as done rises, so the next beat may be taken in the done cycle.
`timescale 1ns / 1ps

module array_list_engine #(
  parameter int DEPTH      = ale_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = ale_pkg::WORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ale_pkg::FUNC_W-1:0]        func,
  input  logic [ale_pkg::POS_W-1:0]         position,
  input  logic signed [ale_pkg::VAL_W-1:0]  item_value,
  output logic                              done,
  output logic [ale_pkg::ST_W-1:0]          status,
  output logic signed [ale_pkg::VAL_W-1:0]  read_value,
  output logic [ale_pkg::IDX_W-1:0]         found_index,
  output logic [ale_pkg::LEN_W-1:0]         list_length
);
  import ale_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  ale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .cmd   (cmd)
  );

  ale_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .position    (position),
    .item_value  (item_value),
    .cmd         (cmd),
    .flags       (flags),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .found_index (found_index),
    .list_length (list_length)
  );

endmodule
